[rtl/kpsd_pkg.sv]
// Package for the keyword posterior smoothing detector: sizes, field
// layout, codes and pipeline record types.
// No dependencies; the top level and the checker take names from here by scope.
package kpsd_pkg;

  // Block sizing
  localparam int NUM_CLASSES = 12;
  localparam int AVG_WINDOW  = 3;
  localparam int SCORE_BITS  = 16;

  localparam int CLASS_W = $clog2(NUM_CLASSES);
  localparam int POS_W   = $clog2(NUM_CLASSES + 1);
  localparam int SLOT_W  = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
  localparam int SUM_W   = SCORE_BITS + 2;
  localparam int WORD_W  = AVG_WINDOW * SCORE_BITS;

  // floor(sum / AVG_WINDOW) as (sum * DIV_RECIP) >> DIV_SHIFT, exact for sum < 2**SUM_W
  localparam int DIV_SHIFT = SUM_W + 2;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(AVG_WINDOW) - 64'd1) / 64'(AVG_WINDOW));
  localparam int AVG_X_W = (SCORE_BITS > 16) ? SCORE_BITS : 17;

  // Port field widths
  localparam int CLASS_FIELD_W = 5;
  localparam int AVG_FIELD_W   = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 32;

  // Output tdata layout, lowest bit up
  localparam int OUT_BEST_LSB = 0;
  localparam int OUT_AVG_LSB  = 5;
  localparam int OUT_RAW_LSB  = 21;
  localparam int OUT_DET_BIT  = 26;
  localparam int OUT_USED_W   = 27;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // Register reset values
  localparam logic [15:0] THRESHOLD_RESET = 16'd58982;
  localparam logic [4:0]  FIRST_KW_RESET  = 5'd2;

  typedef enum logic {
    OP_SCORE        = 1'b0,
    OP_STREAM_RESET = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETECT_THRESHOLD    = 1'b0,
    CFG_FIRST_KEYWORD_CLASS = 1'b1
  } cfg_idx_e;

  typedef logic [SCORE_BITS-1:0]    score_t;
  typedef logic [CLASS_W-1:0]       class_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic [SUM_W-1:0]         sum_t;
  typedef logic [WORD_W-1:0]        word_t;
  typedef logic [PROD_W-1:0]        prod_t;
  typedef logic [AVG_X_W-1:0]       avg_x_t;
  typedef logic [CLASS_FIELD_W-1:0] class_field_t;
  typedef logic [FIFO_CNT_W-1:0]    cnt_t;
  typedef logic [FIFO_PTR_W-1:0]    ptr_t;
  typedef logic [OUT_TDATA_W-1:0]   out_tdata_t;

  // Item on its way to the history update
  typedef struct packed {
    op_e    op;
    logic   last;
    logic   in_range;
    class_t cls;
    pos_t   end_pos;
    score_t score;
  } s2_t;

  // Round end or stream reset on its way to the decision
  typedef struct packed {
    logic   is_result;
    class_t best_class;
    sum_t   best_sum;
    class_t raw_class;
  } s3_t;

  // One result, packed as it leaves on tdata (best_class in the lowest bits)
  typedef struct packed {
    logic                     detected;
    logic [CLASS_FIELD_W-1:0] raw_best_class;
    logic [AVG_FIELD_W-1:0]   best_average;
    logic [CLASS_FIELD_W-1:0] best_class;
  } result_t;

endpackage

[rtl/keyword_posterior_smoothing_detector.sv]
// Top level of the keyword posterior smoothing detector.
// Depends on kpsd_pkg and kpsd_ram (score history store).
// Usage:
//   s_axis: one classifier score per transfer, classes in order from 0.
//     tdata carries the unsigned Q0.16 score, tlast marks the last class
//     of a round, tuser = 1 is a stream reset (score and tlast ignored).
//   m_axis: one result transfer per round end; stream resets give none.
//   cfg: plain write port, index 0 = detect_threshold, 1 = first_keyword_class.
// Throughput: one score per cycle while s_axis_tready is high. Each class keeps its last
//   three scores in one word of the history RAM; a score is a read in the
//   transfer cycle and a modify/write in the next, with forwarding when the
//   next score reads the class just written.
// Result path: the round's last score passes the RAM read, sum and argmax,
//   divide and decide, and then the result queue on its way to m_axis.
// Stalls: results wait in a four-entry queue. Slots are reserved when a
//   round's last score is taken, so s_axis_tready drops only while four
//   results are held or in flight; the pipeline itself never stops.
// Reset: history, running argmax, round position and debounce are cleared
//   at once (history through per-entry valid flops), so the block takes
//   scores from the first cycle after reset. Registers return to 0.90 and 2.
module keyword_posterior_smoothing_detector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [kpsd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [kpsd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // score stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [kpsd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] score
  input  logic                             s_axis_tuser,   // [0] operation
  input  logic                             s_axis_tlast,   // last_class
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [4:0] best_class, [20:5] best_average, [25:21] raw_best_class,
  // [26] detected, [31:27] zero
  output logic [kpsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] thr_q;
  logic [4:0]  fkw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= kpsd_pkg::THRESHOLD_RESET;
      fkw_q <= kpsd_pkg::FIRST_KW_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kpsd_pkg::CFG_DETECT_THRESHOLD:    thr_q <= cfg_data_i;
        kpsd_pkg::CFG_FIRST_KEYWORD_CLASS: fkw_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: accept, track round position, issue history read
  // ---------------------------------------------------------------------
  logic              in_xfer;
  kpsd_pkg::op_e     in_op;
  logic              in_range;
  kpsd_pkg::class_t  cur_cls;
  kpsd_pkg::pos_t    end_pos;
  kpsd_pkg::pos_t    pos_q, pos_d;
  kpsd_pkg::cnt_t    rsv_q, rsv_d;
  logic              rsv_take;
  logic              out_pop;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign in_op    = kpsd_pkg::op_e'(s_axis_tuser);
  assign in_range = pos_q < kpsd_pkg::pos_t'(kpsd_pkg::NUM_CLASSES);
  assign cur_cls  = pos_q[kpsd_pkg::CLASS_W-1:0];
  // position after this score; it holds at NUM_CLASSES for extra scores
  assign end_pos  = in_range ? pos_q + kpsd_pkg::pos_t'(1) : pos_q;

  always_comb begin
    pos_d = pos_q;
    if (in_xfer) begin
      if (in_op == kpsd_pkg::OP_STREAM_RESET || s_axis_tlast) begin
        pos_d = '0;
      end else begin
        pos_d = end_pos;
      end
    end
  end

  // reserve a queue slot for every round end taken in
  assign s_axis_tready = rsv_q < kpsd_pkg::cnt_t'(kpsd_pkg::FIFO_DEPTH);
  assign rsv_take      = in_xfer && in_op == kpsd_pkg::OP_SCORE && s_axis_tlast;
  assign rsv_d         = rsv_q + kpsd_pkg::cnt_t'(rsv_take) - kpsd_pkg::cnt_t'(out_pop);

  kpsd_pkg::s2_t s2_q;
  logic          s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      rsv_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      rsv_q      <= rsv_d;
      s2_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q.op       <= in_op;
    s2_q.last     <= s_axis_tlast;
    s2_q.in_range <= in_range;
    s2_q.cls      <= cur_cls;
    s2_q.end_pos  <= end_pos;
    s2_q.score    <= kpsd_pkg::score_t'(s_axis_tdata);
  end

  // ---------------------------------------------------------------------
  // History RAM: one word per class, one lane per round slot
  // ---------------------------------------------------------------------
  logic             ram_we;
  kpsd_pkg::word_t  ram_rdata;
  kpsd_pkg::word_t  word_new;

  kpsd_ram #(
    .Width (kpsd_pkg::WORD_W),
    .Depth (kpsd_pkg::NUM_CLASSES)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s2_q.cls),
    .wdata_i (word_new),
    .raddr_i (cur_cls),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Stage 2: merge score into the class word, sum, running argmax
  // ---------------------------------------------------------------------
  logic [kpsd_pkg::AVG_WINDOW-1:0][kpsd_pkg::NUM_CLASSES-1:0] hv_q, hv_d;
  kpsd_pkg::slot_t  slot_q, slot_d;
  logic             fwd_q;
  kpsd_pkg::word_t  fwd_word_q;
  kpsd_pkg::word_t  word_in;
  kpsd_pkg::sum_t   sum;

  kpsd_pkg::class_t best_class_q, nb_class;
  kpsd_pkg::sum_t   best_sum_q, nb_sum;
  kpsd_pkg::class_t raw_class_q, nb_raw_class;
  kpsd_pkg::score_t raw_score_q, nb_raw_score;

  logic s2_score, upd, take_best, take_raw, round_end, stream_clr;

  assign word_in    = fwd_q ? fwd_word_q : ram_rdata;
  assign s2_score   = s2_valid_q && s2_q.op == kpsd_pkg::OP_SCORE;
  assign upd        = s2_score && s2_q.in_range;
  assign round_end  = s2_score && s2_q.last;
  assign stream_clr = s2_valid_q && s2_q.op == kpsd_pkg::OP_STREAM_RESET;
  assign ram_we     = upd;

  // lanes never written since the last clear read as zero
  always_comb begin
    kpsd_pkg::score_t lane;
    sum      = '0;
    word_new = '0;
    for (int k = 0; k < kpsd_pkg::AVG_WINDOW; k++) begin
      lane = word_in[k*kpsd_pkg::SCORE_BITS +: kpsd_pkg::SCORE_BITS];
      if (!hv_q[k][s2_q.cls]) begin
        lane = '0;
      end
      if (kpsd_pkg::slot_t'(k) == slot_q) begin
        lane = s2_q.score;
      end
      word_new[k*kpsd_pkg::SCORE_BITS +: kpsd_pkg::SCORE_BITS] = lane;
      sum = sum + kpsd_pkg::sum_t'(lane);
    end
  end

  // lower index wins a tie: replace only on strictly greater
  assign take_best    = upd && (s2_q.cls == '0 || sum > best_sum_q);
  assign take_raw     = upd && (s2_q.cls == '0 || s2_q.score > raw_score_q);
  assign nb_class     = take_best ? s2_q.cls   : best_class_q;
  assign nb_sum       = take_best ? sum        : best_sum_q;
  assign nb_raw_class = take_raw  ? s2_q.cls   : raw_class_q;
  assign nb_raw_score = take_raw  ? s2_q.score : raw_score_q;

  always_comb begin
    hv_d   = hv_q;
    slot_d = slot_q;
    if (stream_clr) begin
      hv_d   = '0;
      slot_d = '0;
    end else begin
      if (upd) begin
        hv_d[slot_q][s2_q.cls] = 1'b1;
      end
      if (round_end) begin
        // classes missing from a short round get zero in this slot
        for (int j = 0; j < kpsd_pkg::NUM_CLASSES; j++) begin
          if (kpsd_pkg::pos_t'(j) >= s2_q.end_pos) begin
            hv_d[slot_q][j] = 1'b0;
          end
        end
        slot_d = (slot_q == kpsd_pkg::slot_t'(kpsd_pkg::AVG_WINDOW - 1)) ?
                 '0 : slot_q + kpsd_pkg::slot_t'(1);
      end
    end
  end

  kpsd_pkg::s3_t s3_q;
  logic          s3_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q         <= '0;
      slot_q       <= '0;
      fwd_q        <= 1'b0;
      best_class_q <= '0;
      best_sum_q   <= '0;
      raw_class_q  <= '0;
      raw_score_q  <= '0;
      s3_valid_q   <= 1'b0;
    end else begin
      hv_q       <= hv_d;
      slot_q     <= slot_d;
      // the read issued this cycle misses the write of the same class
      fwd_q      <= upd && (s2_q.cls == cur_cls);
      s3_valid_q <= round_end || stream_clr;
      if (round_end || stream_clr) begin
        best_class_q <= '0;
        best_sum_q   <= '0;
        raw_class_q  <= '0;
        raw_score_q  <= '0;
      end else begin
        best_class_q <= nb_class;
        best_sum_q   <= nb_sum;
        raw_class_q  <= nb_raw_class;
        raw_score_q  <= nb_raw_score;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_word_q      <= word_new;
    s3_q.is_result  <= round_end;
    s3_q.best_class <= nb_class;
    s3_q.best_sum   <= nb_sum;
    s3_q.raw_class  <= nb_raw_class;
  end

  // ---------------------------------------------------------------------
  // Stage 3: average, saturate, debounce and decide
  // ---------------------------------------------------------------------
  kpsd_pkg::prod_t        prod;
  kpsd_pkg::avg_x_t       avg_x;
  logic [15:0]            avg16;
  kpsd_pkg::class_field_t best5;
  logic                   rep_valid_q, rep_valid_d;
  kpsd_pkg::class_field_t rep_class_q, rep_class_d;
  logic                   det;
  logic                   push;
  kpsd_pkg::result_t      res;

  assign prod  = kpsd_pkg::prod_t'(s3_q.best_sum) * kpsd_pkg::prod_t'(kpsd_pkg::DIV_RECIP);
  assign avg_x = kpsd_pkg::avg_x_t'(prod >> kpsd_pkg::DIV_SHIFT);
  assign avg16 = (avg_x > kpsd_pkg::avg_x_t'(16'hFFFF)) ? 16'hFFFF : avg_x[15:0];
  assign best5 = kpsd_pkg::class_field_t'(s3_q.best_class);
  assign push  = s3_valid_q && s3_q.is_result;

  always_comb begin
    rep_valid_d = rep_valid_q;
    rep_class_d = rep_class_q;
    det         = 1'b0;
    if (s3_valid_q) begin
      if (!s3_q.is_result) begin
        rep_valid_d = 1'b0;
      end else if (best5 < fkw_q) begin
        // filler class: re-arm
        rep_valid_d = 1'b0;
      end else if (avg16 > thr_q && !(rep_valid_q && rep_class_q == best5)) begin
        rep_valid_d = 1'b1;
        rep_class_d = best5;
        det         = 1'b1;
      end
    end
  end

  assign res.detected       = det;
  assign res.raw_best_class = kpsd_pkg::class_field_t'(s3_q.raw_class);
  assign res.best_average   = avg16;
  assign res.best_class     = best5;

  // ---------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------
  kpsd_pkg::result_t fifo_q [kpsd_pkg::FIFO_DEPTH];
  kpsd_pkg::ptr_t    wr_ptr_q, rd_ptr_q;
  kpsd_pkg::cnt_t    cnt_q;

  assign m_axis_tvalid = cnt_q != '0;
  assign out_pop       = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = kpsd_pkg::out_tdata_t'(fifo_q[rd_ptr_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_valid_q <= 1'b0;
      rep_class_q <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
    end else begin
      rep_valid_q <= rep_valid_d;
      rep_class_q <= rep_class_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + kpsd_pkg::ptr_t'(1);
      end
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + kpsd_pkg::ptr_t'(1);
      end
      cnt_q <= cnt_q + kpsd_pkg::cnt_t'(push) - kpsd_pkg::cnt_t'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

endmodule

[rtl/kpsd_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module kpsd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/kpsd_checker.sv]
// Port-level checker for the keyword posterior smoothing detector, bound
// to the top level. Depends on kpsd_pkg for the tdata layout and codes.
module kpsd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tuser,
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [kpsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  // padding above the result fields stays zero
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      m_axis_tdata[kpsd_pkg::OUT_TDATA_W-1:kpsd_pkg::OUT_USED_W] == '0)
    else $error("nonzero padding in result");

  // a detection needs an average above some threshold, so never zero
  a_det_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[kpsd_pkg::OUT_DET_BIT] |->
      m_axis_tdata[kpsd_pkg::OUT_RAW_LSB-1:kpsd_pkg::OUT_AVG_LSB] != '0)
    else $error("detection with zero average");

  // an empty output goes valid only as a result of a round end taken in on s_axis
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && s_axis_tlast &&
            s_axis_tuser == kpsd_pkg::OP_SCORE, 3))
    else $error("result without a round end");

endmodule

bind keyword_posterior_smoothing_detector kpsd_checker u_kpsd_checker (.*);
